@@ design/aart_pkg.sv @@
package aart_pkg;

	// Clip capacity and the widths that follow from it
	localparam int MaxFrames  = 65536;
	localparam int AddrW      = $clog2(MaxFrames);
	localparam int PosW       = 17;
	localparam int SampleW    = 16;
	localparam int MaxWindow  = 1024;
	localparam int WinW       = 11;
	localparam int RatioW     = 15;
	localparam int ThrW       = 15;
	localparam int ThrSqW     = 2 * ThrW;
	localparam int SquareW    = 2 * SampleW - 1;
	localparam int EnergyW    = 41;
	localparam int ProdW      = PosW + RatioW;

	// Stream payload widths
	localparam int InDataW    = 2 * SampleW;
	localparam int OutDataW   = 40;

	// Configuration port
	localparam int CfgIndexW  = 2;
	localparam int CfgDataW   = 15;

	localparam logic [CfgIndexW-1:0] RegWindowLength   = 2'd0;
	localparam logic [CfgIndexW-1:0] RegThresholdRatio = 2'd1;
	localparam logic [CfgIndexW-1:0] RegThresholdFloor = 2'd2;

	localparam logic [WinW-1:0]   WindowLengthReset   = 11'd240;
	localparam logic [RatioW-1:0] ThresholdRatioReset = 15'd2621;
	localparam logic [RatioW-1:0] ThresholdFloorReset = 15'd115;

	// Rounding constant for the Q15 product of peak and ratio
	localparam logic [ProdW:0]    RoundHalf = (ProdW + 1)'(16384);

	// Result field positions inside m_tdata
	localparam int OutStartLsb = 0;
	localparam int OutEndLsb   = PosW;
	localparam int OutQuietBit = 2 * PosW;
	localparam int OutOvfBit   = 2 * PosW + 1;

endpackage

@@ design/aart_ram.sv @@
module aart_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/audio_active_region_trim_core.sv @@
// Silence trimmer for stereo audio clips.
// Input stream: one stereo frame per transfer. s_tdata carries the left sample
// in bits 15:0 and the right sample in bits 31:16; s_tlast marks the final
// frame of a clip. Frames load at one per cycle, each averaged to mono and, while
// the clip memory has room, written to it and folded into the running peak.
// The transfer with s_tlast starts analysis: the threshold is formed, then a
// forward scan finds the first active frame and a backward scan the end of
// the active region. Each tested window is cut at the clip end; the single
// square and accumulate unit reads the memory one sample per cycle. A silent
// clip skips the scans and goes from the threshold product straight to the result.
// s_tready stays low from the last frame until the result is taken.
// Output stream: one result per clip, held in m_tdata until m_tready is high;
// a stalled receiver simply holds the block in that state.
// Clip memory needs no clearing: every read falls inside the stored frames.
// Reset (arst_n low) empties the clip and restores the register defaults.
// Configuration writes take effect at once and are meant for idle times.
module audio_active_region_trim_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// Frame input
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [aart_pkg::InDataW-1:0]        s_tdata,   // left_sample, right_sample
	input  logic                                s_tlast,
	// Result output
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [aart_pkg::OutDataW-1:0]       m_tdata,   // active_start, active_end,
	                                                       // all_quiet, overflowed, zeros
	// Configuration writes
	input  logic                                cfg_we,
	input  logic [aart_pkg::CfgIndexW-1:0]      cfg_index,
	input  logic [aart_pkg::CfgDataW-1:0]       cfg_wdata
);

	localparam int StateW = 4;
	localparam logic [StateW-1:0] ST_IDLE    = 4'd0;
	localparam logic [StateW-1:0] ST_THR_MUL = 4'd1;
	localparam logic [StateW-1:0] ST_THR_MAX = 4'd2;
	localparam logic [StateW-1:0] ST_THR_SQ  = 4'd3;
	localparam logic [StateW-1:0] ST_F_CHECK = 4'd4;
	localparam logic [StateW-1:0] ST_SETUP   = 4'd5;
	localparam logic [StateW-1:0] ST_ACC     = 4'd6;
	localparam logic [StateW-1:0] ST_CMP     = 4'd7;
	localparam logic [StateW-1:0] ST_B_CHECK = 4'd8;
	localparam logic [StateW-1:0] ST_OUT     = 4'd9;

	logic [StateW-1:0]                 state_q;

	// Configuration registers
	logic [aart_pkg::WinW-1:0]         win_len_q;
	logic [aart_pkg::RatioW-1:0]       ratio_q;
	logic [aart_pkg::RatioW-1:0]       floor_q;

	// Clip state
	logic [aart_pkg::PosW-1:0]         count_q;
	logic [aart_pkg::PosW-1:0]         peak_q;
	logic                              ovf_q;

	// Analysis state
	logic [aart_pkg::ProdW-1:0]        prod_q;
	logic [aart_pkg::ThrW-1:0]         thr_q;
	logic [aart_pkg::ThrSqW-1:0]       thr_sq_q;
	logic [aart_pkg::WinW-1:0]         win_q;
	logic [aart_pkg::PosW-1:0]         pos_q;
	logic                              bwd_q;
	logic [aart_pkg::AddrW-1:0]        rd_addr_q;
	logic [aart_pkg::WinW-1:0]         issue_q;
	logic                              v_s1;
	logic                              v_s2;
	logic [aart_pkg::SquareW-1:0]      sq_s2;
	logic [aart_pkg::EnergyW-1:0]      energy_q;
	logic [aart_pkg::EnergyW-1:0]      need_q;

	// Result registers
	logic [aart_pkg::PosW-1:0]         start_q;
	logic [aart_pkg::PosW-1:0]         end_q;
	logic                              quiet_q;

	// Datapath signals
	logic                              s_xfer;
	logic                              m_xfer;
	logic signed [aart_pkg::SampleW:0] mono_sum;
	logic [aart_pkg::SampleW-1:0]      mono;
	logic [aart_pkg::PosW-1:0]         mono_mag;
	logic                              room;
	logic [aart_pkg::SampleW-1:0]      rd_data;
	logic signed [2*aart_pkg::SampleW-1:0] sq_full;
	logic [aart_pkg::ProdW:0]          prod_rnd;
	logic [aart_pkg::ThrW-1:0]         thr_prod;
	logic [aart_pkg::PosW-1:0]         remain;
	logic [aart_pkg::WinW-1:0]         win_n;
	logic [aart_pkg::PosW:0]           start_next;
	logic                              active;

	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_xfer   = m_tvalid && m_tready;

	assign m_tdata = {
		{(aart_pkg::OutDataW - aart_pkg::OutOvfBit - 1){1'b0}},
		ovf_q, quiet_q, end_q, start_q
	};

	// Stereo to mono: sum and arithmetic shift right by one.
	assign mono_sum = $signed({s_tdata[aart_pkg::SampleW-1], s_tdata[aart_pkg::SampleW-1:0]})
		+ $signed({s_tdata[aart_pkg::InDataW-1], s_tdata[aart_pkg::InDataW-1:aart_pkg::SampleW]});
	assign mono     = mono_sum[aart_pkg::SampleW:1];
	assign mono_mag = mono[aart_pkg::SampleW-1]
		? aart_pkg::PosW'(-$signed({1'b1, mono}))
		: aart_pkg::PosW'(mono);
	assign room     = !count_q[aart_pkg::AddrW];

	// Clip memory
	aart_ram #(
		.WIDTH(aart_pkg::SampleW),
		.DEPTH(aart_pkg::MaxFrames)
	) u_store (
		.clk  (clk),
		.we   (s_xfer && room),
		.waddr(count_q[aart_pkg::AddrW-1:0]),
		.wdata(mono),
		.raddr(rd_addr_q),
		.rdata(rd_data)
	);

	// Square of the sample read back
	assign sq_full = $signed(rd_data) * $signed(rd_data);

	// Rounded Q15 product, known to fit the threshold width
	assign prod_rnd = {1'b0, prod_q} + aart_pkg::RoundHalf;
	assign thr_prod = prod_rnd[aart_pkg::ThrW+14:15];

	// Window size at the current position, cut at the clip end
	assign remain = count_q - pos_q;
	assign win_n  = (remain < aart_pkg::PosW'(win_q)) ? remain[aart_pkg::WinW-1:0] : win_q;

	assign start_next = {1'b0, start_q} + 1'b1;
	assign active     = (energy_q >= need_q);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= aart_pkg::WindowLengthReset;
			ratio_q   <= aart_pkg::ThresholdRatioReset;
			floor_q   <= aart_pkg::ThresholdFloorReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aart_pkg::RegWindowLength:   win_len_q <= cfg_wdata[aart_pkg::WinW-1:0];
				aart_pkg::RegThresholdRatio: ratio_q   <= cfg_wdata;
				aart_pkg::RegThresholdFloor: floor_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Read pipeline into the square and accumulate unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_ACC) && (issue_q != '0);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			sq_s2 <= sq_full[aart_pkg::SquareW-1:0];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			peak_q    <= '0;
			ovf_q     <= 1'b0;
			prod_q    <= '0;
			thr_q     <= '0;
			thr_sq_q  <= '0;
			win_q     <= '0;
			pos_q     <= '0;
			bwd_q     <= 1'b0;
			issue_q   <= '0;
			energy_q  <= '0;
			need_q    <= '0;
			rd_addr_q <= '0;
			start_q   <= '0;
			end_q     <= '0;
			quiet_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						if (room) begin
							count_q <= count_q + 1'b1;
							if (mono_mag > peak_q) begin
								peak_q <= mono_mag;
							end
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_THR_MUL;
						end
					end
				end
				ST_THR_MUL: begin
					prod_q <= aart_pkg::ProdW'(peak_q) * aart_pkg::ProdW'(ratio_q);
					if (win_len_q == '0) begin
						win_q <= aart_pkg::WinW'(1);
					end else if (win_len_q > aart_pkg::WinW'(aart_pkg::MaxWindow)) begin
						win_q <= aart_pkg::WinW'(aart_pkg::MaxWindow);
					end else begin
						win_q <= win_len_q;
					end
					if (peak_q == '0) begin
						start_q <= '0;
						end_q   <= count_q;
						quiet_q <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_THR_MAX;
					end
				end
				ST_THR_MAX: begin
					thr_q   <= (floor_q > thr_prod) ? floor_q : thr_prod;
					state_q <= ST_THR_SQ;
				end
				ST_THR_SQ: begin
					thr_sq_q <= aart_pkg::ThrSqW'(thr_q) * aart_pkg::ThrSqW'(thr_q);
					quiet_q  <= 1'b0;
					pos_q    <= '0;
					bwd_q    <= 1'b0;
					state_q  <= ST_F_CHECK;
				end
				// Forward scan: give up when the clip is exhausted.
				ST_F_CHECK: begin
					if (pos_q >= count_q) begin
						start_q <= count_q;
						end_q   <= count_q;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_SETUP;
					end
				end
				// Prepare one window test at pos_q.
				ST_SETUP: begin
					rd_addr_q <= pos_q[aart_pkg::AddrW-1:0];
					issue_q   <= win_n;
					need_q    <= aart_pkg::EnergyW'(thr_sq_q) * aart_pkg::EnergyW'(win_n);
					energy_q  <= '0;
					state_q   <= ST_ACC;
				end
				// Stream the window through the square unit into the sum.
				ST_ACC: begin
					if (issue_q != '0) begin
						issue_q   <= issue_q - 1'b1;
						rd_addr_q <= rd_addr_q + 1'b1;
					end
					if (v_s2) begin
						energy_q <= energy_q + aart_pkg::EnergyW'(sq_s2);
					end
					if (issue_q == '0 && !v_s1 && !v_s2) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (!bwd_q) begin
						if (active) begin
							start_q <= pos_q;
							end_q   <= count_q;
							bwd_q   <= 1'b1;
							state_q <= ST_B_CHECK;
						end else begin
							pos_q   <= pos_q + 1'b1;
							state_q <= ST_F_CHECK;
						end
					end else begin
						if (active) begin
							state_q <= ST_OUT;
						end else begin
							end_q   <= end_q - 1'b1;
							state_q <= ST_B_CHECK;
						end
					end
				end
				// Backward scan: test the frame just below the current end.
				ST_B_CHECK: begin
					if ({1'b0, end_q} > start_next) begin
						pos_q   <= end_q - 1'b1;
						state_q <= ST_SETUP;
					end else begin
						state_q <= ST_OUT;
					end
				end
				// Hold the result until its transfer, then empty the clip.
				ST_OUT: begin
					if (m_xfer) begin
						count_q <= '0;
						peak_q  <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/aart_checker.sv @@
module aart_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic                                s_tlast,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [aart_pkg::OutDataW-1:0]       m_tdata
);

	logic [aart_pkg::PosW-1:0] res_start;
	logic [aart_pkg::PosW-1:0] res_end;
	logic                      res_quiet;

	assign res_start = m_tdata[aart_pkg::OutStartLsb +: aart_pkg::PosW];
	assign res_end   = m_tdata[aart_pkg::OutEndLsb +: aart_pkg::PosW];
	assign res_quiet = m_tdata[aart_pkg::OutQuietBit];

	// A stalled result stays put until its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	// No frame is taken while a result waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while a result is pending");

	// A frame that does not end the clip keeps the input open.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> s_tready)
		else $error("input stalled after an ordinary frame");

	// The active region never runs backward.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_start <= res_end)
		else $error("active start beyond active end");

	// A silent clip reports the whole clip from frame zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_quiet |-> res_start == '0)
		else $error("quiet clip with nonzero start");

endmodule

bind audio_active_region_trim_core aart_checker u_aart_checker (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	localparam int SampleMax     = (1 << (aart_pkg::SampleW - 1)) - 1;
	localparam int RandomFrames  = 530;
	localparam int SettleCycles  = 16;
	localparam int TailCycles    = 32;
	localparam int WatchdogLimit = 200000;

	// Index 3 decodes to no register; writes there must change nothing.
	localparam logic [aart_pkg::CfgIndexW-1:0] RegUnmapped = 2'd3;

	typedef enum logic [1:0] {
		FeedFrame,
		FeedDrain,
		FeedWrite
	} feed_kind_e;

	typedef struct packed {
		feed_kind_e                          kind;
		logic signed [aart_pkg::SampleW-1:0] left;
		logic signed [aart_pkg::SampleW-1:0] right;
		logic                                last;
		logic [aart_pkg::CfgIndexW-1:0]      reg_index;
		logic [aart_pkg::CfgDataW-1:0]       reg_value;
	} feed_item_t;

	typedef struct packed {
		logic [aart_pkg::PosW-1:0] start_pos;
		logic [aart_pkg::PosW-1:0] end_pos;
		logic                      all_quiet;
		logic                      overflowed;
	} region_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [aart_pkg::InDataW-1:0]   s_tdata = '0;     // left_sample, right_sample
	logic                           s_tlast = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [aart_pkg::OutDataW-1:0]  m_tdata;          // active_start, active_end, all_quiet,
	                                                  // overflowed, zeros
	logic                           cfg_we = 1'b0;
	logic [aart_pkg::CfgIndexW-1:0] cfg_index = '0;
	logic [aart_pkg::CfgDataW-1:0]  cfg_wdata = '0;

	// Pending stimulus and the regions the trimmer should report.
	feed_item_t feed_q[$];
	region_t    region_q[$];
	feed_item_t on_wire;

	// Clip state and register copies of the prediction.
	int clip_mono [aart_pkg::MaxFrames];
	int clip_len = 0;
	int clip_peak = 0;
	bit clip_dropped = 1'b0;
	int win_cfg = int'(aart_pkg::WindowLengthReset);
	int ratio_cfg = int'(aart_pkg::ThresholdRatioReset);
	int floor_cfg = int'(aart_pkg::ThresholdFloorReset);

	int burst_left;
	int gap_left;
	int settle_left;
	int stall_mode;
	logic [5:0] stall_phase;
	int idle_cycles;
	int mismatches = 0;

	audio_active_region_trim_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A window is hot when its mean square reaches the squared threshold.
	function automatic bit window_hot(int pos, int win, longint thr_sq);
		int     stop;
		longint energy;
		stop = pos + win;
		if (stop > clip_len)
			stop = clip_len;
		if (stop <= pos)
			return 1'b0;
		energy = 0;
		for (int i = pos; i < stop; i++)
			energy += longint'(clip_mono[i]) * clip_mono[i];
		return energy >= thr_sq * (stop - pos);
	endfunction

	// Fold one accepted frame into the clip; a final frame yields the trimmed region.
	function automatic void absorb_frame(feed_item_t it);
		int      mono;
		int      mag;
		int      win;
		int      first;
		int      stop;
		longint  thr;
		region_t region;
		mono = (int'($signed(it.left)) + int'($signed(it.right))) >>> 1;
		if (clip_len < aart_pkg::MaxFrames) begin
			mag = (mono < 0) ? -mono : mono;
			clip_mono[clip_len] = mono;
			clip_len++;
			if (mag > clip_peak)
				clip_peak = mag;
		end else begin
			clip_dropped = 1'b1;
		end
		if (!it.last)
			return;
		if (clip_peak == 0) begin
			first = 0;
			stop = clip_len;
		end else begin
			win = (win_cfg == 0) ? 1 : win_cfg;
			if (win > aart_pkg::MaxWindow)
				win = aart_pkg::MaxWindow;
			thr = (longint'(clip_peak) * ratio_cfg + 16384) >>> 15;
			if (longint'(floor_cfg) > thr)
				thr = floor_cfg;
			first = 0;
			while (first < clip_len && !window_hot(first, win, thr * thr))
				first++;
			stop = clip_len;
			while (stop > first + 1 && !window_hot(stop - 1, win, thr * thr))
				stop--;
		end
		region.start_pos = first[aart_pkg::PosW-1:0];
		region.end_pos = stop[aart_pkg::PosW-1:0];
		region.all_quiet = (clip_peak == 0);
		region.overflowed = clip_dropped;
		region_q.insert(region_q.size(), region);
		clip_len = 0;
		clip_peak = 0;
		clip_dropped = 1'b0;
	endfunction

	function automatic void check_field(string field, logic [aart_pkg::PosW-1:0] want,
			logic [aart_pkg::PosW-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	// Random sample in [-amp, amp]; an amplitude past full scale means any code.
	function automatic int pick_sample(int amp);
		if (amp > SampleMax)
			return int'($signed(aart_pkg::SampleW'($urandom)));
		return int'($urandom_range(0, 2 * amp)) - amp;
	endfunction

	task automatic queue_frame(int l, int r, bit last);
		feed_item_t it;
		it = '0;
		it.kind = FeedFrame;
		it.left = aart_pkg::SampleW'(l);
		it.right = aart_pkg::SampleW'(r);
		it.last = last;
		feed_q.insert(feed_q.size(), it);
	endtask

	task automatic queue_write(logic [aart_pkg::CfgIndexW-1:0] index, int value);
		feed_item_t it;
		it = '0;
		it.kind = FeedWrite;
		it.reg_index = index;
		it.reg_value = aart_pkg::CfgDataW'(value);
		feed_q.insert(feed_q.size(), it);
	endtask

	// Registers change only once the trimmer has gone idle.
	task automatic queue_setting(int win, int ratio, int flo);
		feed_item_t it;
		it = '0;
		it.kind = FeedDrain;
		feed_q.insert(feed_q.size(), it);
		queue_write(aart_pkg::RegWindowLength, win);
		queue_write(aart_pkg::RegThresholdRatio, ratio);
		queue_write(aart_pkg::RegThresholdFloor, flo);
	endtask

	// Frame driver: bursts with random gaps, drains before register writes.
	always @(posedge clk or negedge arst_n) begin : feed_driver
		feed_item_t head;
		logic       hold;
		logic       next_valid;
		logic       next_we;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			cfg_we <= 1'b0;
			cfg_index <= '0;
			cfg_wdata <= '0;
			burst_left = 1;
			gap_left = 0;
			settle_left = SettleCycles;
		end else begin
			next_we = 1'b0;
			hold = s_tvalid && !s_tready;
			if (s_tvalid && s_tready) begin
				absorb_frame(on_wire);
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 32);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			next_valid = hold;
			if (!hold) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (feed_q.size() > 0) begin
					head = feed_q[0];
					case (head.kind)
						FeedFrame: begin
							void'(feed_q.pop_front());
							on_wire = head;
							next_valid = 1'b1;
							s_tdata <= {head.right, head.left};
							s_tlast <= head.last;
						end
						FeedDrain: begin
							if (region_q.size() != 0) begin
								settle_left = SettleCycles;
							end else if (settle_left > 0) begin
								settle_left--;
							end else begin
								void'(feed_q.pop_front());
								settle_left = SettleCycles;
							end
						end
						default: begin
							void'(feed_q.pop_front());
							next_we = 1'b1;
							cfg_index <= head.reg_index;
							cfg_wdata <= head.reg_value;
							case (head.reg_index)
								aart_pkg::RegWindowLength:
									win_cfg = int'(head.reg_value[aart_pkg::WinW-1:0]);
								aart_pkg::RegThresholdRatio:
									ratio_cfg = int'(head.reg_value[aart_pkg::RatioW-1:0]);
								aart_pkg::RegThresholdFloor:
									floor_cfg = int'(head.reg_value[aart_pkg::ThrW-1:0]);
								default: ;
							endcase
						end
					endcase
				end
			end
			s_tvalid <= next_valid;
			cfg_we <= next_we;
		end
	end

	// Result receiver: the stall pattern is picked anew each time the six-bit phase counter wraps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_phase <= '0;
			stall_mode = 0;
		end else begin
			stall_phase <= stall_phase + 1'b1;
			if (stall_phase == '0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				2:       m_tready <= (stall_phase[3:0] == 4'hf);
				default: m_tready <= (stall_phase[2:0] != 3'd0);
			endcase
		end
	end

	// Result checker and the count of cycles with no transfer.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		region_t want;
		region_t got;
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (m_tvalid && m_tready) begin
				got.start_pos = m_tdata[aart_pkg::OutStartLsb +: aart_pkg::PosW];
				got.end_pos = m_tdata[aart_pkg::OutEndLsb +: aart_pkg::PosW];
				got.all_quiet = m_tdata[aart_pkg::OutQuietBit];
				got.overflowed = m_tdata[aart_pkg::OutOvfBit];
				if (region_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual start %0d end %0d",
						$time, got.start_pos, got.end_pos);
					mismatches++;
				end else begin
					want = region_q.pop_front();
					check_field("active_start", want.start_pos, got.start_pos);
					check_field("active_end", want.end_pos, got.end_pos);
					check_field("all_quiet", aart_pkg::PosW'(want.all_quiet),
						aart_pkg::PosW'(got.all_quiet));
					check_field("overflowed", aart_pkg::PosW'(want.overflowed),
						aart_pkg::PosW'(got.overflowed));
				end
			end
		end
	end

	initial begin : run
		int len;
		int head_len;
		int body_len;
		int quiet_amp;
		int loud_amp;
		int shape;
		int l;
		int r;
		int win;
		int ratio;
		int flo;
		int clips;
		int random_frames;
		int tail;

		// Reset defaults: full-scale codes and rounding of the mono average.
		queue_frame(0, 0, 1'b0);
		queue_frame(SampleMax, SampleMax, 1'b0);
		queue_frame(-SampleMax - 1, -SampleMax - 1, 1'b0);
		queue_frame(-1, 0, 1'b1);
		// Silent clip built from channels that cancel.
		queue_frame(0, 0, 1'b0);
		queue_frame(1, -1, 1'b0);
		queue_frame(-SampleMax, SampleMax, 1'b1);
		// One-frame clip.
		queue_frame(-SampleMax - 1, SampleMax, 1'b1);

		// Zero window length acts as one frame; full ratio, no floor.
		queue_setting(0, SampleMax, 0);
		queue_write(RegUnmapped, $urandom_range(0, SampleMax));
		queue_frame(0, 0, 1'b0);
		queue_frame(0, 0, 1'b0);
		queue_frame(1000, 1000, 1'b0);
		queue_frame(-1000, -1000, 1'b0);
		queue_frame(0, 0, 1'b0);
		queue_frame(0, 0, 1'b1);

		// Floor at full scale: no frame can be active.
		queue_setting(2, 0, SampleMax);
		queue_frame(100, -50, 1'b0);
		queue_frame(200, 200, 1'b0);
		queue_frame(-300, 0, 1'b0);
		queue_frame(7, 7, 1'b0);
		queue_frame(1, 0, 1'b1);

		// Oversized window saturates; one loud frame lies just past its reach.
		queue_setting(2047, 512, 1);
		for (int i = 0; i < 1100; i++) begin
			if (i == 1050)
				queue_frame(SampleMax, SampleMax, 1'b0);
			else
				queue_frame(0, 0, i == 1099);
		end

		// Random settings, each followed by a few clips with quiet head and tail.
		random_frames = 0;
		while (random_frames < RandomFrames) begin
			case ($urandom_range(0, 7))
				0:       win = 0;
				1:       win = 1;
				2:       win = aart_pkg::MaxWindow;
				3:       win = 2047;
				4, 5:    win = $urandom_range(1, 8);
				default: win = $urandom_range(1, 48);
			endcase
			if ($urandom_range(0, 7) == 0)
				win += $urandom_range(1, 15) << aart_pkg::WinW;
			case ($urandom_range(0, 5))
				0:       ratio = 0;
				1:       ratio = SampleMax;
				2:       ratio = int'(aart_pkg::ThresholdRatioReset);
				default: ratio = $urandom_range(0, SampleMax);
			endcase
			case ($urandom_range(0, 5))
				0:       flo = 0;
				1:       flo = SampleMax;
				2:       flo = int'(aart_pkg::ThresholdFloorReset);
				3:       flo = $urandom_range(0, SampleMax);
				default: flo = $urandom_range(0, 1024);
			endcase
			queue_setting(win, ratio, flo);
			if ($urandom_range(0, 3) == 0)
				queue_write(RegUnmapped, $urandom_range(0, SampleMax));

			clips = $urandom_range(1, 5);
			for (int c = 0; c < clips; c++) begin
				shape = $urandom_range(0, 9);
				case ($urandom_range(0, 3))
					0:       quiet_amp = 0;
					1:       quiet_amp = 1;
					2:       quiet_amp = 64;
					default: quiet_amp = $urandom_range(0, 512);
				endcase
				loud_amp = ($urandom_range(0, 1) == 0) ? SampleMax + 1 :
					$urandom_range(64, SampleMax);
				if (shape == 0) begin
					head_len = $urandom_range(1, 12);
					body_len = 0;
					quiet_amp = SampleMax;
				end else if (shape <= 2) begin
					head_len = 0;
					body_len = $urandom_range(1, 40);
					loud_amp = SampleMax + 1;
				end else begin
					head_len = $urandom_range(0, 12);
					body_len = $urandom_range(1, 20);
				end
				len = head_len + body_len + ((shape > 2) ? $urandom_range(0, 12) : 0);
				for (int i = 0; i < len; i++) begin
					if (i < head_len || i >= head_len + body_len)
						l = pick_sample(quiet_amp);
					else
						l = pick_sample(loud_amp);
					// Cancelling channels give a silent clip with busy input bits.
					if (shape == 0)
						r = -l;
					else if (i < head_len || i >= head_len + body_len)
						r = pick_sample(quiet_amp);
					else
						r = pick_sample(loud_amp);
					queue_frame(l, r, i == len - 1);
				end
				random_frames += len;
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Run until all frames are taken and every region has been reported.
		while (idle_cycles < WatchdogLimit &&
				!(feed_q.size() == 0 && !s_tvalid && region_q.size() == 0))
			@(negedge clk);
		tail = 0;
		while (idle_cycles < WatchdogLimit && tail < TailCycles) begin
			@(negedge clk);
			tail++;
		end
		if (idle_cycles >= WatchdogLimit) begin
			$display("%0t: watchdog expired, expected a transfer within %0d cycles, actual none",
				$time, WatchdogLimit);
			mismatches++;
		end
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
